/* hdl/sfpp_pkg.sv */
// Package with the shared types, constants and the CRC function of the flash page programmer.
`timescale 1ns / 1ps

package sfpp_pkg;

	// Geometry of the flash region and of the file registers.
	localparam int ADDR_W       = 23;
	localparam int SIZE_W       = 24;
	localparam int PAGE_BYTES   = 256;
	localparam int SECTOR_BYTES = 4096;
	localparam int REGION_END   = 8388608;
	localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
	localparam int SECT_SHIFT   = $clog2(SECTOR_BYTES);
	localparam int SECT_W       = ADDR_W - SECT_SHIFT;
	localparam int SUM_W        = SIZE_W + 1;
	localparam int CFG_W        = SIZE_W;

	// Result queue geometry: one word can cause up to three results.
	localparam int MAX_RES  = 3;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Input request codes.
	localparam logic REQ_BEGIN = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_START_ADDRESS = 1'b0;
	localparam logic REG_FILE_SIZE     = 1'b1;

	typedef enum logic [2:0] {
		K_ERASE        = 3'd0,
		K_PROGRAM      = 3'd1,
		K_COMPLETE     = 3'd2,
		K_BYTE_REJECT  = 3'd3,
		K_START_OK     = 3'd4,
		K_START_REJECT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1
	} phase_t;

	// One result word.
	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         pbyte;
		logic               pend;
		logic [15:0]        crc;
		logic               last;
	} result_t;

	// Results produced by one accepted input word, in order.
	typedef struct packed {
		logic [1:0]                 cnt;
		result_t [MAX_RES-1:0]      res;
	} push_t;

	// CRC-16/CCITT over one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hdl/sfpp_core.sv */
// Command logic of the flash page programmer: registers, file state and result generation.
`timescale 1ns / 1ps

module sfpp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sfpp_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        accept,
	input  logic                        req_type,
	input  logic [7:0]                  data_byte,
	output sfpp_pkg::push_t             push
);

	logic [sfpp_pkg::ADDR_W-1:0] start_address_q;
	logic [sfpp_pkg::SIZE_W-1:0] file_size_q;
	sfpp_pkg::phase_t            phase_q;
	logic [sfpp_pkg::SIZE_W-1:0] bytes_done_q;
	logic [sfpp_pkg::SECT_W-1:0] erased_sector_q;
	logic                        erased_valid_q;
	logic [15:0]                 crc_q;

	sfpp_pkg::phase_t            phase_d;
	logic [sfpp_pkg::SIZE_W-1:0] bytes_done_d;
	logic [sfpp_pkg::SECT_W-1:0] erased_sector_d;
	logic                        erased_valid_d;
	logic [15:0]                 crc_d;

	logic [sfpp_pkg::SUM_W-1:0]  end_sum;
	logic [sfpp_pkg::ADDR_W-1:0] addr;
	logic [sfpp_pkg::SECT_W-1:0] sector;
	logic [sfpp_pkg::SIZE_W-1:0] bytes_next;
	logic [15:0]                 crc_next;
	logic                        is_last;
	logic                        need_erase;
	logic                        page_close;
	sfpp_pkg::result_t           r_erase;
	sfpp_pkg::result_t           r_prog;
	sfpp_pkg::result_t           r_done;
	sfpp_pkg::result_t           r_single;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= '0;
			file_size_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfpp_pkg::REG_START_ADDRESS: start_address_q <= cfg_data[sfpp_pkg::ADDR_W-1:0];
				sfpp_pkg::REG_FILE_SIZE:     file_size_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Address, sector, CRC and end-of-file terms for a data word.
	always_comb begin
		end_sum    = {2'b00, start_address_q} + {1'b0, file_size_q};
		addr       = start_address_q + bytes_done_q[sfpp_pkg::ADDR_W-1:0];
		sector     = addr[sfpp_pkg::ADDR_W-1:sfpp_pkg::SECT_SHIFT];
		bytes_next = bytes_done_q + sfpp_pkg::SIZE_W'(1);
		crc_next   = sfpp_pkg::crc_byte(crc_q, data_byte);
		is_last    = (bytes_next == file_size_q);
		need_erase = !erased_valid_q || (sector != erased_sector_q);
		page_close = (&addr[sfpp_pkg::PAGE_SHIFT-1:0]) || is_last;
	end

	// Result words and next state for the accepted word.
	always_comb begin
		r_erase       = '0;
		r_erase.kind  = sfpp_pkg::K_ERASE;
		r_erase.addr  = {sector, {sfpp_pkg::SECT_SHIFT{1'b0}}};

		r_prog        = '0;
		r_prog.kind   = sfpp_pkg::K_PROGRAM;
		r_prog.addr   = addr;
		r_prog.pbyte  = data_byte;
		r_prog.pend   = page_close;
		r_prog.crc    = crc_next;
		r_prog.last   = !is_last;

		r_done        = '0;
		r_done.kind   = sfpp_pkg::K_COMPLETE;
		r_done.crc    = crc_next;
		r_done.last   = 1'b1;

		r_single      = '0;
		r_single.last = 1'b1;

		phase_d         = phase_q;
		bytes_done_d    = bytes_done_q;
		erased_sector_d = erased_sector_q;
		erased_valid_d  = erased_valid_q;
		crc_d           = crc_q;

		push     = '0;
		push.cnt = 2'd0;

		if (accept) begin
			case (req_type)
				sfpp_pkg::REQ_BEGIN: begin
					if (phase_q != sfpp_pkg::PH_IDLE || file_size_q == '0 ||
					    end_sum > sfpp_pkg::SUM_W'(sfpp_pkg::REGION_END)) begin
						r_single.kind = sfpp_pkg::K_START_REJECT;
					end else begin
						r_single.kind   = sfpp_pkg::K_START_OK;
						r_single.addr   = start_address_q;
						r_single.crc    = sfpp_pkg::CRC_INIT;
						phase_d         = sfpp_pkg::PH_RECV;
						bytes_done_d    = '0;
						erased_sector_d = '0;
						erased_valid_d  = 1'b0;
						crc_d           = sfpp_pkg::CRC_INIT;
					end
					push.cnt    = 2'd1;
					push.res[0] = r_single;
				end
				default: begin
					if (phase_q != sfpp_pkg::PH_RECV || bytes_done_q >= file_size_q) begin
						r_single.kind = sfpp_pkg::K_BYTE_REJECT;
						push.cnt      = 2'd1;
						push.res[0]   = r_single;
					end else begin
						bytes_done_d = bytes_next;
						crc_d        = crc_next;
						if (need_erase) begin
							erased_sector_d = sector;
							erased_valid_d  = 1'b1;
						end
						if (is_last) begin
							phase_d = sfpp_pkg::PH_IDLE;
						end
						// Pack erase, program and completion words in order.
						if (need_erase) begin
							push.res[0] = r_erase;
							push.res[1] = r_prog;
							push.res[2] = r_done;
							push.cnt    = is_last ? 2'd3 : 2'd2;
						end else begin
							push.res[0] = r_prog;
							push.res[1] = r_done;
							push.cnt    = is_last ? 2'd2 : 2'd1;
						end
					end
				end
			endcase
		end
	end

	// File state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= sfpp_pkg::PH_IDLE;
			bytes_done_q    <= '0;
			erased_sector_q <= '0;
			erased_valid_q  <= 1'b0;
			crc_q           <= sfpp_pkg::CRC_INIT;
		end else begin
			phase_q         <= phase_d;
			bytes_done_q    <= bytes_done_d;
			erased_sector_q <= erased_sector_d;
			erased_valid_q  <= erased_valid_d;
			crc_q           <= crc_d;
		end
	end

endmodule

/* hdl/sfpp_result_queue.sv */
// Page programmer result queue: takes up to three words at once, gives one a cycle if out_ready.
`timescale 1ns / 1ps

module sfpp_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  sfpp_pkg::push_t    push,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output sfpp_pkg::result_t  out_res
);

	sfpp_pkg::result_t              entry_q [sfpp_pkg::QDEPTH];
	logic [sfpp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sfpp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sfpp_pkg::QCNT_W-1:0]    count_q;
	logic                           pop;

	// Room for a full group of results is kept before a word is taken.
	assign space     = (count_q <= sfpp_pkg::QCNT_W'(sfpp_pkg::QDEPTH - sfpp_pkg::MAX_RES));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < sfpp_pkg::MAX_RES; i++) begin
			if (2'(i) < push.cnt) begin
				entry_q[wr_ptr_q + sfpp_pkg::QPTR_W'(i)] <= push.res[i];
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sfpp_pkg::QPTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sfpp_pkg::QPTR_W'(1);
			end
			count_q <= count_q + sfpp_pkg::QCNT_W'(push.cnt) - sfpp_pkg::QCNT_W'(pop);
		end
	end

endmodule

/* hdl/stream_flash_page_programmer.sv */
// Top level of the stream-to-serial-flash page programmer.
// Result words are registered in the result queue before they are offered.
// Throughput: one input word per cycle while each causes one result and out_ready is high;
// the result port gives one word per cycle, so a word with an erase or completion slows the input.
// A four-entry result queue sets this figure: input is taken while three entries are free.
// Reset (arst_n low, asynchronous): idle, registers zero, CRC 0xFFFF, queue empty.
`timescale 1ns / 1ps

module stream_flash_page_programmer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sfpp_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  result_kind,
	output logic [sfpp_pkg::ADDR_W-1:0] flash_address,
	output logic [7:0]                  program_byte,
	output logic                        page_end,
	output logic [15:0]                 crc_value,
	output logic                        last
);

	sfpp_pkg::push_t   push;
	sfpp_pkg::result_t out_res;
	logic              space;
	logic              accept;

	// Input word handshake.
	assign in_ready = space;
	assign accept   = in_valid && space;

	sfpp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.req_type  (req_type),
		.data_byte (data_byte),
		.push      (push)
	);

	sfpp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Result word fields.
	assign result_kind   = out_res.kind;
	assign flash_address = out_res.addr;
	assign program_byte  = out_res.pbyte;
	assign page_end      = out_res.pend;
	assign crc_value     = out_res.crc;
	assign last          = out_res.last;

endmodule
